// ===== src/sorted_port_table_neighbours_top_macros.svh =====
// Assertion macros for the sorted port table.
// Included by the top-level RTL module, which carries the concurrent checks; no other dependencies.
`ifndef SORTED_PORT_TABLE_NEIGHBOURS_TOP_MACROS_SVH
`define SORTED_PORT_TABLE_NEIGHBOURS_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPTN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPTN_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sptn_pkg.sv =====
// Shared types and constants for the sorted port table.
// No dependencies; imported by the cell, the top level and the testbench.
`default_nettype none

package sptn_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int PORT_W = 16;
  localparam int COUNT_OUT_W = 5;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // per-cycle command to every cell
  typedef struct packed {
    logic upd;
    logic del;
  } cell_ctrl_t;

  // compare results a cell reports to its neighbors and the top level
  typedef struct packed {
    logic lt;
    logic first;
    logic last_lt;
    logic hit;
  } cell_flags_t;

endpackage

`default_nettype wire

// ===== src/sptn_cell.sv =====
// One entry of the sorted port table: holds a port, compares it and shifts.
// Depends on sptn_pkg.
`default_nettype none

module sptn_cell (
  input  wire                       clk,
  input  sptn_pkg::cell_ctrl_t      ctrl,
  input  wire [sptn_pkg::PORT_W-1:0] port,
  input  wire                       occ,
  input  wire [sptn_pkg::PORT_W-1:0] value_left,
  input  wire                       lt_left,
  input  wire [sptn_pkg::PORT_W-1:0] value_right,
  input  wire                       lt_right,
  output logic [sptn_pkg::PORT_W-1:0] value,
  output sptn_pkg::cell_flags_t     flags
);
  import sptn_pkg::*;

  logic [PORT_W-1:0] value_next;

  always_comb begin
    flags.lt      = occ && (value < port);
    flags.first   = occ && !flags.lt && lt_left;
    flags.last_lt = flags.lt && !lt_right;
    flags.hit     = flags.first && (value == port);
  end

  always_comb begin
    if (flags.lt) begin
      value_next = value;
    end else if (ctrl.del) begin
      value_next = value_right;
    end else if (lt_left) begin
      value_next = port;
    end else begin
      value_next = value_left;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      value <= value_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/sorted_port_table_neighbours_top.sv =====
// Sorted port table: a row of CAPACITY cells holds the ports in ascending order.
// The transfer cycle registers the request; then, in the busy state, every cell
// compares the port at once, the row shifts by one place if the operation succeeds
// and the result register is loaded. The result register parts the two sides; a stalled
// result holds the compare-and-shift cycle of the following item until it is taken.
// Depends on sptn_pkg, sptn_cell and sorted_port_table_neighbours_top_macros.svh.
`default_nettype none

module sorted_port_table_neighbours_top #(
  parameter int CAPACITY = sptn_pkg::CAPACITY_DEFAULT
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            req_valid,
  output logic                           req_ready,
  input  wire                            mode,
  input  wire [sptn_pkg::PORT_W-1:0]     port,
  output logic                           rsp_valid,
  input  wire                            rsp_ready,
  output logic [sptn_pkg::PORT_W-1:0]    left_port,
  output logic                           has_left,
  output logic [sptn_pkg::PORT_W-1:0]    right_port,
  output logic                           has_right,
  output logic [sptn_pkg::PORT_W-1:0]    outer_left_port,
  output logic                           has_outer_left,
  output logic [sptn_pkg::PORT_W-1:0]    outer_right_port,
  output logic                           has_outer_right,
  output logic [sptn_pkg::COUNT_OUT_W-1:0] entry_count,
  output logic [sptn_pkg::STATUS_W-1:0]  status
);
  import sptn_pkg::*;
  `include "sorted_port_table_neighbours_top_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic              state;
  logic              mode_q;
  logic [PORT_W-1:0] port_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  logic [PORT_W-1:0] value [CAPACITY];
  cell_flags_t       flags [CAPACITY];
  cell_ctrl_t        ctrl;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] sel_left;
  logic [CAPACITY-1:0] sel_oleft;
  logic [CAPACITY-1:0] sel_right;
  logic [CAPACITY-1:0] sel_oright;

  logic commit;
  logic is_insert;
  logic full;
  logic hit_any;
  logic done;
  logic [PORT_W-1:0] left_sel;
  logic [PORT_W-1:0] oleft_sel;
  logic [PORT_W-1:0] right_sel;
  logic [PORT_W-1:0] oright_sel;

  assign req_ready = (state == ST_IDLE);
  assign commit    = (state == ST_BUSY) && (!rsp_valid || rsp_ready);
  assign is_insert = (mode_q == MODE_INSERT);
  assign full      = (count >= CNT_W'(CAPACITY));
  assign hit_any   = |hit_vec;
  assign done      = is_insert ? !full : hit_any;

  assign ctrl.upd = commit && done;
  assign ctrl.del = !is_insert;

  always_comb begin
    count_next = count;
    if (commit && done) begin
      count_next = is_insert ? count + 1'b1 : count - 1'b1;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [PORT_W-1:0] v_left;
      logic [PORT_W-1:0] v_right;
      logic              l_left;
      logic              l_right;

      assign occ[i] = (CNT_W'(i) < count);

      if (i == 0) begin : g_head
        assign v_left = value[i];
        assign l_left = 1'b1;
      end else begin : g_mid_l
        assign v_left = value[i-1];
        assign l_left = flags[i-1].lt;
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign v_right = value[i];
        assign l_right = 1'b0;
      end else begin : g_mid_r
        assign v_right = value[i+1];
        assign l_right = flags[i+1].lt;
      end

      sptn_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .port        (port_q),
        .occ         (occ[i]),
        .value_left  (v_left),
        .lt_left     (l_left),
        .value_right (v_right),
        .lt_right    (l_right),
        .value       (value[i]),
        .flags       (flags[i])
      );

      assign hit_vec[i]  = flags[i].hit;
      assign sel_left[i] = flags[i].last_lt;

      if (i + 1 < CAPACITY) begin : g_ol
        assign sel_oleft[i] = flags[i+1].last_lt;
      end else begin : g_ol_none
        assign sel_oleft[i] = 1'b0;
      end

      if (i == 0) begin : g_r0
        assign sel_right[i]  = is_insert && flags[i].first;
        assign sel_oright[i] = 1'b0;
      end else if (i == 1) begin : g_r1
        assign sel_right[i]  = is_insert ? flags[i].first : (flags[i-1].first && occ[i]);
        assign sel_oright[i] = is_insert && flags[i-1].first && occ[i];
      end else begin : g_rn
        assign sel_right[i]  = is_insert ? flags[i].first : (flags[i-1].first && occ[i]);
        assign sel_oright[i] = occ[i] && (is_insert ? flags[i-1].first : flags[i-2].first);
      end
    end
  endgenerate

  always_comb begin
    left_sel   = '0;
    oleft_sel  = '0;
    right_sel  = '0;
    oright_sel = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      left_sel   = left_sel   | (sel_left[k]   ? value[k] : '0);
      oleft_sel  = oleft_sel  | (sel_oleft[k]  ? value[k] : '0);
      right_sel  = right_sel  | (sel_right[k]  ? value[k] : '0);
      oright_sel = oright_sel | (sel_oright[k] ? value[k] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      mode_q <= mode;
      port_q <= port;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      left_port        <= done ? left_sel : '0;
      has_left         <= done && (|sel_left);
      outer_left_port  <= done ? oleft_sel : '0;
      has_outer_left   <= done && (|sel_oleft);
      right_port       <= done ? right_sel : '0;
      has_right        <= done && (|sel_right);
      outer_right_port <= done ? oright_sel : '0;
      has_outer_right  <= done && (|sel_oright);
      entry_count      <= COUNT_OUT_W'(count_next);
      if (done) begin
        status <= STATUS_DONE;
      end else if (is_insert) begin
        status <= STATUS_FULL;
      end else begin
        status <= STATUS_ABSENT;
      end
    end
  end

  `SPTN_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(CAPACITY),
    "entry count above capacity")
  `SPTN_ASSERT_NXT(a_insert_grows, clk, rst, commit && done && is_insert,
    count == $past(count) + 1'b1, "insert did not grow the table by one")
  `SPTN_ASSERT_NXT(a_accept_busy, clk, rst, req_valid && req_ready,
    state == ST_BUSY && !req_ready, "transfer did not start an operation")
  `SPTN_ASSERT_IMP(a_order, clk, rst, rsp_valid && has_left && has_right,
    left_port <= right_port, "neighbors out of order")
  `SPTN_ASSERT_IMP(a_ignored_empty, clk, rst, rsp_valid && status != STATUS_DONE,
    !has_left && !has_right && !has_outer_left && !has_outer_right,
    "ignored operation reports neighbors")

endmodule

`default_nettype wire

// ===== test/tb_sorted_port_table_neighbours_top.sv =====
// Testbench for sorted_port_table_neighbours_top: a directed table of inserts and deletes,
// then random traffic checked against an in-bench sorted table predictor.
// Depends on sptn_pkg and the RTL of sorted_port_table_neighbours_top only.
`timescale 1ns / 1ps

module tb_sorted_port_table_neighbours_top;
  import sptn_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_OPS = 1550;

  typedef struct packed {
    logic [PORT_W-1:0]      left_port;
    logic                   has_left;
    logic [PORT_W-1:0]      right_port;
    logic                   has_right;
    logic [PORT_W-1:0]      outer_left_port;
    logic                   has_outer_left;
    logic [PORT_W-1:0]      outer_right_port;
    logic                   has_outer_right;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [STATUS_W-1:0]    status;
  } nbr_rsp_t;

  typedef struct {
    logic              op;
    logic [PORT_W-1:0] p;
    bit                fixed;
    nbr_rsp_t          want;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_ready;
  logic                   mode;
  logic [PORT_W-1:0]      port;
  logic                   rsp_valid;
  logic                   rsp_ready;
  logic [PORT_W-1:0]      left_port;
  logic                   has_left;
  logic [PORT_W-1:0]      right_port;
  logic                   has_right;
  logic [PORT_W-1:0]      outer_left_port;
  logic                   has_outer_left;
  logic [PORT_W-1:0]      outer_right_port;
  logic                   has_outer_right;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic [STATUS_W-1:0]    status;

  logic [PORT_W-1:0] ports_held [TABLE_DEPTH];
  int                held_count;
  nbr_rsp_t          expected_nbrs [$];
  dir_row_t          dir_rows [$];
  int                mismatch_count;
  int                send_idle_pct;
  int                recv_idle_pct;

  sorted_port_table_neighbours_top #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .mode(mode),
    .port(port),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .left_port(left_port),
    .has_left(has_left),
    .right_port(right_port),
    .has_right(has_right),
    .outer_left_port(outer_left_port),
    .has_outer_left(has_outer_left),
    .outer_right_port(outer_right_port),
    .has_outer_right(has_outer_right),
    .entry_count(entry_count),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  function automatic void table_at(input int idx, output logic [PORT_W-1:0] v,
                                   output logic present);
    if (idx >= 0 && idx < held_count) begin
      v = ports_held[idx];
      present = 1'b1;
    end else begin
      v = '0;
      present = 1'b0;
    end
  endfunction

  // Applies one operation to the shadow table and returns the neighbour report.
  function automatic nbr_rsp_t apply_port_op(logic op, logic [PORT_W-1:0] p);
    nbr_rsp_t r;
    int pos;
    int k;
    r = '0;
    pos = 0;
    while (pos < held_count && ports_held[pos] < p) pos++;
    if (op == MODE_INSERT) begin
      if (held_count >= TABLE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        for (k = held_count; k > pos; k--) ports_held[k] = ports_held[k-1];
        ports_held[pos] = p;
        held_count++;
        table_at(pos - 1, r.left_port, r.has_left);
        table_at(pos + 1, r.right_port, r.has_right);
        table_at(pos - 2, r.outer_left_port, r.has_outer_left);
        table_at(pos + 2, r.outer_right_port, r.has_outer_right);
        r.status = STATUS_DONE;
      end
    end else begin
      if (pos >= held_count || ports_held[pos] != p) begin
        r.status = STATUS_ABSENT;
      end else begin
        for (k = pos; k + 1 < held_count; k++) ports_held[k] = ports_held[k+1];
        held_count--;
        table_at(pos - 1, r.left_port, r.has_left);
        table_at(pos, r.right_port, r.has_right);
        table_at(pos - 2, r.outer_left_port, r.has_outer_left);
        table_at(pos + 1, r.outer_right_port, r.has_outer_right);
        r.status = STATUS_DONE;
      end
    end
    r.entry_count = held_count[COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic nbr_rsp_t quiet_rsp(int count, logic [STATUS_W-1:0] st);
    nbr_rsp_t r;
    r = '0;
    r.entry_count = count[COUNT_OUT_W-1:0];
    r.status = st;
    return r;
  endfunction

  function automatic void add_row(logic op, logic [PORT_W-1:0] p, bit fixed, nbr_rsp_t want);
    dir_row_t row;
    row.op = op;
    row.p = p;
    row.fixed = fixed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  task automatic send_port_op(logic op, logic [PORT_W-1:0] p, bit fixed, nbr_rsp_t want);
    nbr_rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      mode <= 1'($urandom_range(1));
      port <= PORT_W'($urandom);
      @(negedge clk);
    end
    req_valid <= 1'b1;
    mode <= op;
    port <= p;
    do @(posedge clk); while (!req_ready);
    predicted = apply_port_op(op, p);
    expected_nbrs.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [PORT_W-1:0] exp_v, logic [PORT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  function automatic logic [PORT_W-1:0] pick_port();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) return PORT_W'($urandom);
    if (sel < 70) return PORT_W'($urandom_range(7));
    if (sel < 80) return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    if (held_count > 0)
      return PORT_W'(ports_held[$urandom_range(held_count - 1)] + $urandom_range(2) - 1);
    return PORT_W'($urandom);
  endfunction

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    nbr_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_nbrs.size() == 0) begin
        $display("%0t unexpected result: expected none, got count %0d status %0d",
                 $time, entry_count, status);
        mismatch_count++;
      end else begin
        want = expected_nbrs.pop_front();
        check_field("left_port", want.left_port, left_port);
        check_field("has_left", PORT_W'(want.has_left), PORT_W'(has_left));
        check_field("right_port", want.right_port, right_port);
        check_field("has_right", PORT_W'(want.has_right), PORT_W'(has_right));
        check_field("outer_left_port", want.outer_left_port, outer_left_port);
        check_field("has_outer_left", PORT_W'(want.has_outer_left), PORT_W'(has_outer_left));
        check_field("outer_right_port", want.outer_right_port, outer_right_port);
        check_field("has_outer_right", PORT_W'(want.has_outer_right),
                    PORT_W'(has_outer_right));
        check_field("entry_count", PORT_W'(want.entry_count), PORT_W'(entry_count));
        check_field("status", PORT_W'(want.status), PORT_W'(status));
      end
    end
  end

  initial begin
    int i;
    int target_fill;
    logic op;
    logic [PORT_W-1:0] p;
    rst = 1'b1;
    req_valid = 1'b0;
    mode = MODE_INSERT;
    port = '0;
    rsp_ready = 1'b0;
    held_count = 0;
    mismatch_count = 0;
    send_idle_pct = 21;
    recv_idle_pct = 81;
    target_fill = 8;

    // directed rows: empty delete, extremes, duplicate, delete, absent delete, fill, full insert, end deletes
    add_row(MODE_DELETE, 16'h0000, 1'b1, quiet_rsp(0, STATUS_ABSENT));
    add_row(MODE_INSERT, 16'h0000, 1'b1, quiet_rsp(1, STATUS_DONE));
    add_row(MODE_INSERT, 16'hFFFF, 1'b0, '0);
    add_row(MODE_INSERT, 16'h0000, 1'b0, '0);
    add_row(MODE_INSERT, 16'h8000, 1'b0, '0);
    add_row(MODE_INSERT, 16'h7FFF, 1'b0, '0);
    add_row(MODE_DELETE, 16'h8000, 1'b0, '0);
    add_row(MODE_DELETE, 16'h1234, 1'b1, quiet_rsp(4, STATUS_ABSENT));
    for (i = 0; i < 12; i++) add_row(MODE_INSERT, 16'h0010 << i, 1'b0, '0);
    add_row(MODE_INSERT, 16'h5555, 1'b1, quiet_rsp(16, STATUS_FULL));
    add_row(MODE_DELETE, 16'hFFFF, 1'b0, '0);
    add_row(MODE_DELETE, 16'h0000, 1'b0, '0);
    add_row(MODE_DELETE, 16'h0000, 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[j])
      send_port_op(dir_rows[j].op, dir_rows[j].p, dir_rows[j].fixed, dir_rows[j].want);

    for (i = 0; i < RANDOM_OPS; i++) begin
      if (i == RANDOM_OPS / 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 21;
      end else if (i == 2 * RANDOM_OPS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i % 64 == 0) target_fill = $urandom_range(TABLE_DEPTH);
      if (held_count == 0) begin
        op = ($urandom_range(9) == 0) ? MODE_DELETE : MODE_INSERT;
      end else if (held_count >= TABLE_DEPTH) begin
        op = ($urandom_range(9) == 0) ? MODE_INSERT : MODE_DELETE;
      end else if (held_count < target_fill) begin
        op = ($urandom_range(3) == 0) ? MODE_DELETE : MODE_INSERT;
      end else begin
        op = ($urandom_range(3) == 0) ? MODE_INSERT : MODE_DELETE;
      end
      if (op == MODE_DELETE && held_count > 0 && $urandom_range(99) < 85)
        p = ports_held[$urandom_range(held_count - 1)];
      else
        p = pick_port();
      send_port_op(op, p, 1'b0, '0);
    end
    req_valid <= 1'b0;

    while (expected_nbrs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/sptn_pkg.sv
src/sptn_cell.sv
src/sorted_port_table_neighbours_top.sv
test/tb_sorted_port_table_neighbours_top.sv
